[hdl/ccs_pkg.sv]
`default_nettype none

package ccs_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4,
        MODE_STR    = 3'd5,
        MODE_CHR    = 3'd6
    } lex_mode_t;

    typedef struct packed {
        logic              last;
        logic              eol;
        logic [CHAR_W-1:0] ch;
    } res_item_t;

endpackage

`default_nettype wire

[hdl/c_comment_stripper.sv]
// Channel   Dir  tdata        tuser     tlast
// s_axis    in   [7:0] ch     [0] eol   -
// m_axis    out  [7:0] out_ch [0] out_eol last
//
// One source word is taken per cycle while s_axis_tready is high; a word
// that releases a held '/' gives two result words.
// Results go through a four-word output queue; s_axis_tready is high while
// the queue has room for two words, so a stall on m_axis holds the input.
// rst_n clears the lexer mode, the escape flag and the queue pointers.
`default_nettype none

module c_comment_stripper
    import ccs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [CHAR_W-1:0] s_axis_tdata,  // [7:0] ch
    input  wire logic              s_axis_tuser,  // [0] eol
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [CHAR_W-1:0] m_axis_tdata,  // [7:0] out_ch
    output logic                   m_axis_tuser,  // [0] out_eol
    output logic                   m_axis_tlast
);

    lex_mode_t   mode_reg, mode_next;
    logic        esc_reg, esc_next;
    res_item_t   q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    logic        in_acc, out_acc;
    logic [1:0]  n_res;
    res_item_t   r0, r1;
    logic [CHAR_W-1:0] c;
    logic        eol;

    lex_mode_t   nb_mode;
    logic        nb_emit;
    logic        nb_clr_esc;
    logic [CHAR_W-1:0] quote;

    assign c   = s_axis_tdata;
    assign eol = s_axis_tuser;

    assign s_axis_tready = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (cnt_reg != '0);
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = q_reg[rd_ptr_reg].ch;
    assign m_axis_tuser  = q_reg[rd_ptr_reg].eol;
    assign m_axis_tlast  = q_reg[rd_ptr_reg].last;

    always_comb
    begin
        nb_emit    = 1'b1;
        nb_clr_esc = 1'b0;
        nb_mode    = MODE_NORMAL;
        if (c == CH_SLASH)
        begin
            nb_emit = 1'b0;
            nb_mode = MODE_SLASH;
        end
        else if (c == CH_DQUOTE)
        begin
            nb_mode    = MODE_STR;
            nb_clr_esc = 1'b1;
        end
        else if (c == CH_SQUOTE)
        begin
            nb_mode    = MODE_CHR;
            nb_clr_esc = 1'b1;
        end
    end

    assign quote = (mode_reg == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        if (eol)
        begin
            if (mode_reg == MODE_BLOCK || mode_reg == MODE_STAR)
                mode_next = MODE_BLOCK;
            else
                mode_next = MODE_NORMAL;
            esc_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg) inside
                MODE_SLASH:
                begin
                    if (c == CH_SLASH)
                        mode_next = MODE_LINE;
                    else if (c == CH_STAR)
                        mode_next = MODE_BLOCK;
                    else
                    begin
                        mode_next = nb_mode;
                        if (nb_clr_esc)
                            esc_next = 1'b0;
                    end
                end
                MODE_LINE:
                begin
                end
                MODE_BLOCK:
                begin
                    if (c == CH_STAR)
                        mode_next = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (c == CH_SLASH)
                        mode_next = MODE_NORMAL;
                    else if (c != CH_STAR)
                        mode_next = MODE_BLOCK;
                end
                MODE_STR, MODE_CHR:
                begin
                    if (!esc_reg && c == quote)
                    begin
                        mode_next = MODE_NORMAL;
                        esc_next  = 1'b0;
                    end
                    else
                        esc_next = !esc_reg && (c == CH_BSLASH);
                end
                default:
                begin
                    mode_next = nb_mode;
                    if (nb_clr_esc)
                        esc_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        n_res = 2'd0;
        r0    = '{last: 1'b0, eol: 1'b0, ch: c};
        r1    = '{last: 1'b0, eol: 1'b0, ch: c};
        if (eol)
        begin
            if (mode_reg == MODE_SLASH)
            begin
                n_res = 2'd2;
                r0.ch = CH_SLASH;
                r1    = '{last: 1'b0, eol: 1'b1, ch: '0};
            end
            else
            begin
                n_res = 2'd1;
                r0    = '{last: 1'b0, eol: 1'b1, ch: '0};
            end
        end
        else
        begin
            unique case (mode_reg) inside
                MODE_SLASH:
                begin
                    if (c != CH_SLASH && c != CH_STAR)
                    begin
                        n_res = 2'd2;
                        r0.ch = CH_SLASH;
                    end
                end
                MODE_LINE, MODE_BLOCK, MODE_STAR:
                begin
                end
                MODE_STR, MODE_CHR:
                begin
                    n_res = 2'd1;
                end
                default:
                begin
                    n_res = nb_emit ? 2'd1 : 2'd0;
                end
            endcase
        end
        if (n_res == 2'd2)
            r1.last = 1'b1;
        else
            r0.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            esc_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                mode_reg   <= mode_next;
                esc_reg    <= esc_next;
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_res);
            end
            if (out_acc)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (in_acc ? QCNT_W'(n_res) : '0)
                               - (out_acc ? QCNT_W'(1) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && n_res != 2'd0)
            q_reg[wr_ptr_reg] <= r0;
        if (in_acc && n_res == 2'd2)
            q_reg[QPTR_W'(wr_ptr_reg + 1'b1)] <= r1;
    end

endmodule

`default_nettype wire

[hdl/ccs_checker.sv]
`default_nettype none

module ccs_checker
    import ccs_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic [CHAR_W-1:0] s_axis_tdata,
    input wire logic              s_axis_tuser,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [CHAR_W-1:0] m_axis_tdata,
    input wire logic              m_axis_tuser,
    input wire logic              m_axis_tlast
);

    logic unused_in;
    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ s_axis_tuser ^ (^s_axis_tdata);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_eol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("end-of-line word carries a character");

    a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("end-of-line word not marked last");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second word of a pair missing");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
